/* rtl/core/tlfs_pkg.sv */
// Shared types and constants for the two-level free slot finder.
// Holds the request/result structs, request kind codes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package tlfs_pkg;

    // Field widths fixed by the request/result format
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 20;

    // Slot bits are stored eight to a memory row
    localparam int ROW_W  = 8;
    localparam int ROW_SH = 3;

    // Request kinds
    localparam logic [KIND_W-1:0] K_SET     = 3'd0;
    localparam logic [KIND_W-1:0] K_COUNT   = 3'd1;
    localparam logic [KIND_W-1:0] K_REFRESH = 3'd2;
    localparam logic [KIND_W-1:0] K_FIND    = 3'd3;
    localparam logic [KIND_W-1:0] K_WRITE   = 3'd4;

    // Saturation limits
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
    localparam int TOTAL_MAX = 524287;
    localparam int TOTAL_MIN = -524288;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [7:0]                slot_index;
        logic                      slot_value;
        logic [3:0]                group_index;
        logic                      is_addition;
        logic signed [TOTAL_W-1:0] total_value;
    } req_t;

    typedef struct packed {
        logic                      found;
        logic [7:0]                free_index;
        logic                      any_free;
        logic signed [TOTAL_W-1:0] total_now;
    } rsp_t;

endpackage

/* rtl/core/tlfs_ram.sv */
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the slot bit rows and the group counts. No dependencies.
`timescale 1ns / 1ps

module tlfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/two_level_free_slot_finder.sv */
// Top level of the two-level free slot finder: request sequencer around
// two tlfs_ram instances (slot bit rows, group counts). Uses tlfs_pkg.
//
// Usage:
//   A request (req) is taken when start is high and busy is low. Each request
//   produces exactly one result on rsp, shown for one cycle with done high;
//   the receiver cannot hold it off, and done only shows while busy is low.
//   Write total, an unknown kind and an out-of-range set/count finish straight
//   from idle; set slot and count change pass through a write state (S_SET or
//   S_CNT). A find with no positive count ends after the group walk; at worst
//   (group 0 positive, no free) it also walks every slot row.
//   The refresh and the find walk the count memory one group a cycle through
//   its single read port; the find then walks the slot memory one 8-slot row
//   a cycle. One request is in work at a time; a new one may start in the
//   cycle its predecessor's result is shown.
//   After reset the block clears every slot row and every group count, one
//   address a cycle, with busy held high; the stored total resets to zero.
`timescale 1ns / 1ps

module two_level_free_slot_finder
    import tlfs_pkg::*;
#(
    parameter int GROUPS = 16,
    parameter int SLOTS  = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int ROWS  = (SLOTS + ROW_W - 1) / ROW_W;
    localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int GW    = $clog2(GROUPS);
    localparam int CLR_N = (ROWS > GROUPS) ? ROWS : GROUPS;
    localparam int CLW   = $clog2(CLR_N) + 1;
    localparam int JW0   = $clog2(GROUPS * GROUPS + SLOTS + 1);
    localparam int JW    = (JW0 > 9) ? JW0 : 9;
    localparam int ACC_W = (COUNT_W + GW > TOTAL_W) ? COUNT_W + GW : TOTAL_W + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SET   = 3'd2;
    localparam logic [2:0] S_CNT   = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_FGRP  = 3'd5;
    localparam logic [2:0] S_FSLOT = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic [CLW-1:0]            clr_reg, clr_next;
    logic [GW-1:0]             ptr_reg, ptr_next;
    logic [RAW-1:0]            row_reg, row_next;
    logic                      first_reg, first_next;
    req_t                      req_reg, req_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic                      done_reg, done_next;
    rsp_t                      rsp_reg, rsp_next;

    // Memory ports
    logic               slot_we;
    logic [RAW-1:0]     slot_waddr, slot_raddr;
    logic [ROW_W-1:0]   slot_wdata, slot_rdata;
    logic               cnt_we;
    logic [GW-1:0]      cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

    // Datapath helpers
    logic signed [COUNT_W-1:0] cnt_val, cnt_mod;
    logic signed [ACC_W-1:0]   sum;
    logic signed [TOTAL_W-1:0] sum_sat;
    logic [JW-1:0]             grp_start;
    logic [RAW-1:0]            grp_row;
    logic [ROW_SH-1:0]         grp_off;
    logic                      grp_in;
    logic                      set_in, cnt_in;
    logic [ROW_W-1:0]          off_mask, masked, set_row;
    logic [ROW_SH-1:0]         enc;
    logic                      hit;

    tlfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS),
        .AW    (RAW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    tlfs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (GROUPS),
        .AW    (GW)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Saturating count update
    always_comb
    begin
        cnt_val = $signed(cnt_rdata);
        cnt_mod = cnt_val;
        if (req_reg.is_addition)
        begin
            if (cnt_val != COUNT_MAX)
            begin
                cnt_mod = cnt_val + 16'sd1;
            end
        end
        else
        begin
            if (cnt_val != COUNT_MIN)
            begin
                cnt_mod = cnt_val - 16'sd1;
            end
        end
    end

    // Running sum of counts, saturated to the total's range at the end
    always_comb
    begin
        sum = acc_reg + ACC_W'(cnt_val);
        if (sum > ACC_W'(TOTAL_MAX))
        begin
            sum_sat = TOTAL_W'(TOTAL_MAX);
        end
        else if (sum < ACC_W'(TOTAL_MIN))
        begin
            sum_sat = TOTAL_W'(TOTAL_MIN);
        end
        else
        begin
            sum_sat = TOTAL_W'(sum);
        end
    end

    // First slot of the current group and the row scan
    always_comb
    begin
        grp_start = JW'(ptr_reg) * JW'(GROUPS);
        grp_row   = RAW'(grp_start >> ROW_SH);
        grp_off   = grp_start[ROW_SH-1:0];
        grp_in    = grp_start < JW'(SLOTS);
        off_mask  = ~((ROW_W'(1) << grp_off) - ROW_W'(1));
        masked    = first_reg ? (slot_rdata & off_mask) : slot_rdata;
        hit       = |masked;
        enc       = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                enc = ROW_SH'(i);
            end
        end
    end

    // Range checks on the incoming request and the row update for a set
    always_comb
    begin
        set_in  = JW'(req.slot_index) < JW'(SLOTS);
        cnt_in  = JW'(req.group_index) < JW'(GROUPS);
        set_row = slot_rdata;
        set_row[req_reg.slot_index[ROW_SH-1:0]] = req_reg.slot_value;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ptr_next   = ptr_reg;
        row_next   = row_reg;
        first_next = first_reg;
        req_next   = req_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        done_next  = 1'b0;
        rsp_next   = '0;

        slot_we    = 1'b0;
        slot_waddr = RAW'(req_reg.slot_index >> ROW_SH);
        slot_wdata = set_row;
        slot_raddr = grp_row;
        cnt_we     = 1'b0;
        cnt_waddr  = GW'(req_reg.group_index);
        cnt_wdata  = cnt_mod;
        cnt_raddr  = ptr_reg + GW'(1);

        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we    = clr_reg < CLW'(ROWS);
                slot_waddr = clr_reg[RAW-1:0];
                slot_wdata = '0;
                cnt_we     = clr_reg < CLW'(GROUPS);
                cnt_waddr  = clr_reg[GW-1:0];
                cnt_wdata  = '0;
                if (clr_reg == CLW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CLW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    ptr_next = '0;
                    acc_next = '0;
                    unique case (req.kind)
                        K_SET:
                        begin
                            slot_raddr = RAW'(req.slot_index >> ROW_SH);
                            if (set_in)
                            begin
                                state_next = S_SET;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        K_COUNT:
                        begin
                            cnt_raddr = GW'(req.group_index);
                            if (cnt_in)
                            begin
                                state_next = S_CNT;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        K_REFRESH:
                        begin
                            cnt_raddr  = '0;
                            state_next = S_SUM;
                        end
                        K_FIND:
                        begin
                            cnt_raddr  = '0;
                            state_next = S_FGRP;
                        end
                        K_WRITE:
                        begin
                            total_next = req.total_value;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SET:
            begin
                slot_we    = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_CNT:
            begin
                cnt_we     = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_SUM:
            begin
                acc_next = sum;
                if (ptr_reg == GW'(GROUPS - 1))
                begin
                    total_next = sum_sat;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + GW'(1);
                end
            end

            S_FGRP:
            begin
                // slot row of this group is read ahead in case it is positive
                row_next   = grp_row;
                first_next = 1'b1;
                if (cnt_val > 16'sd0)
                begin
                    if (grp_in)
                    begin
                        state_next = S_FSLOT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (ptr_reg == GW'(GROUPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + GW'(1);
                end
            end

            S_FSLOT:
            begin
                slot_raddr = row_reg + RAW'(1);
                if (hit)
                begin
                    rsp_next.found      = 1'b1;
                    rsp_next.free_index = 8'({row_reg, enc});
                    done_next           = 1'b1;
                    state_next          = S_IDLE;
                end
                else if (row_reg == RAW'(ROWS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_next   = row_reg + RAW'(1);
                    first_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next.any_free  = total_next > 20'sd0;
        rsp_next.total_now = total_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        row_reg   <= row_next;
        first_reg <= first_next;
        req_reg   <= req_next;
        acc_reg   <= acc_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* rtl/core/tlfs_check.sv */
// Port-level checks for the two-level free slot finder, bound to the top.
// Uses tlfs_pkg for the result struct.
`timescale 1ns / 1ps

module tlfs_check
    import tlfs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // An accepted request either finishes at once or holds the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request neither finished nor held busy");

    // Results only show once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // A miss reports index zero
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.found) |-> (rsp.free_index == 8'd0))
        else $error("nonzero index on a miss");

    // any_free agrees with the reported total
    a_any_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.any_free == ($signed(rsp.total_now) > 20'sd0)))
        else $error("any_free disagrees with total");

endmodule

bind two_level_free_slot_finder tlfs_check u_tlfs_check (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
